/* design/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg: shared types, constants and microprogram
// Command and status types, register indexes and the sequencer program of
// the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

   localparam int RAW_W   = 24;
   localparam int SCALE_W = 24;
   localparam int COEF_W  = 48;
   localparam int Q_W     = 26;
   localparam int QUO_W   = 46;
   localparam int ACC_W   = 76;
   localparam int PROD_W  = 51;
   localparam int MA_W    = 25;
   localparam int INT_W   = 48;
   localparam int OUT_W   = 40;
   localparam int PC_W    = 5;
   localparam int CNT_W   = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUO_W);

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_MID  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_SCALE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_SCALE = 3'd4;

   localparam logic [SCALE_W-1:0] TEMP_SCALE_RESET  = 24'd3670016;
   localparam logic [SCALE_W-1:0] PRESS_SCALE_RESET = 24'd7864320;

   localparam logic [PC_W-1:0] PRESS_START = 5'd0;
   localparam logic [PC_W-1:0] TEMP_START  = 5'd26;

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_RUN, ST_OUT} ctrl_state_type;

   typedef enum logic [2:0] {
      LD_NONE, LD_ZERO, LD_C20, LD_C10, LD_C11, LD_C00, LD_C0
   } load_sel_type;

   typedef enum logic [2:0] {MA_C30, MA_C21, MA_C01, MA_C1, MA_XH, MA_XL} mul_a_type;

   typedef enum logic {MY_P, MY_T} mul_y_type;

   typedef enum logic [2:0] {ADD_NONE, ADD_PROD, ADD_PROD_HI, ADD_X, ADD_E} add_sel_type;

   typedef enum logic [1:0] {STO_NONE, STO_X_SAT, STO_X_MULQ, STO_E_MULQ} store_type;

   typedef enum logic {OSH_TEMP, OSH_PRESS} out_shift_type;

   typedef struct packed {
      load_sel_type  load;
      mul_a_type     mul_a;
      mul_y_type     mul_y;
      logic          mul_en;
      add_sel_type   add;
      store_type     store;
      logic          last;
      out_shift_type osh;
   } uop_type;

   typedef struct packed {
      logic    start;
      uop_type uop;
      logic    out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } dp_stat_type;

   function automatic uop_type mk_uop(load_sel_type ld, mul_a_type ma, mul_y_type my,
                                      logic me, add_sel_type ad, store_type st,
                                      logic lst, out_shift_type osh);
      uop_type u;
      u.load   = ld;
      u.mul_a  = ma;
      u.mul_y  = my;
      u.mul_en = me;
      u.add    = ad;
      u.store  = st;
      u.last   = lst;
      u.osh    = osh;
      return u;
   endfunction

   localparam uop_type UOP_NOP = '{LD_NONE, MA_C30, MY_P, 1'b0, ADD_NONE, STO_NONE,
                                   1'b0, OSH_TEMP};

   // Pressure program from PRESS_START, temperature program from TEMP_START.
   function automatic uop_type prog(logic [PC_W-1:0] pc);
      uop_type u;
      u = UOP_NOP;
      unique case (pc)
         5'd0:  u = mk_uop(LD_C20, MA_C30, MY_P, 1'b1, ADD_NONE, STO_NONE, 1'b0, OSH_PRESS);
         5'd1:  u = mk_uop(LD_NONE, MA_C30, MY_P, 1'b0, ADD_PROD, STO_NONE, 1'b0, OSH_PRESS);
         5'd2:  u = mk_uop(LD_ZERO, MA_C30, MY_P, 1'b0, ADD_NONE, STO_X_SAT, 1'b0, OSH_PRESS);
         5'd3:  u = mk_uop(LD_NONE, MA_XH, MY_P, 1'b1, ADD_NONE, STO_NONE, 1'b0, OSH_PRESS);
         5'd4:  u = mk_uop(LD_NONE, MA_XL, MY_P, 1'b1, ADD_PROD_HI, STO_NONE, 1'b0, OSH_PRESS);
         5'd5:  u = mk_uop(LD_NONE, MA_XL, MY_P, 1'b0, ADD_PROD, STO_NONE, 1'b0, OSH_PRESS);
         5'd6:  u = mk_uop(LD_C10, MA_C30, MY_P, 1'b0, ADD_NONE, STO_X_MULQ, 1'b0, OSH_PRESS);
         5'd7:  u = mk_uop(LD_NONE, MA_C30, MY_P, 1'b0, ADD_X, STO_NONE, 1'b0, OSH_PRESS);
         5'd8:  u = mk_uop(LD_ZERO, MA_C30, MY_P, 1'b0, ADD_NONE, STO_X_SAT, 1'b0, OSH_PRESS);
         5'd9:  u = mk_uop(LD_NONE, MA_XH, MY_P, 1'b1, ADD_NONE, STO_NONE, 1'b0, OSH_PRESS);
         5'd10: u = mk_uop(LD_NONE, MA_XL, MY_P, 1'b1, ADD_PROD_HI, STO_NONE, 1'b0, OSH_PRESS);
         5'd11: u = mk_uop(LD_NONE, MA_XL, MY_P, 1'b0, ADD_PROD, STO_NONE, 1'b0, OSH_PRESS);
         5'd12: u = mk_uop(LD_C11, MA_C21, MY_P, 1'b1, ADD_NONE, STO_E_MULQ, 1'b0, OSH_PRESS);
         5'd13: u = mk_uop(LD_NONE, MA_C21, MY_P, 1'b0, ADD_PROD, STO_NONE, 1'b0, OSH_PRESS);
         5'd14: u = mk_uop(LD_ZERO, MA_C30, MY_P, 1'b0, ADD_NONE, STO_X_SAT, 1'b0, OSH_PRESS);
         5'd15: u = mk_uop(LD_NONE, MA_XH, MY_P, 1'b1, ADD_NONE, STO_NONE, 1'b0, OSH_PRESS);
         5'd16: u = mk_uop(LD_NONE, MA_XL, MY_P, 1'b1, ADD_PROD_HI, STO_NONE, 1'b0, OSH_PRESS);
         5'd17: u = mk_uop(LD_NONE, MA_XL, MY_P, 1'b0, ADD_PROD, STO_NONE, 1'b0, OSH_PRESS);
         5'd18: u = mk_uop(LD_ZERO, MA_C30, MY_P, 1'b0, ADD_NONE, STO_X_MULQ, 1'b0, OSH_PRESS);
         5'd19: u = mk_uop(LD_NONE, MA_XH, MY_T, 1'b1, ADD_NONE, STO_NONE, 1'b0, OSH_PRESS);
         5'd20: u = mk_uop(LD_NONE, MA_XL, MY_T, 1'b1, ADD_PROD_HI, STO_NONE, 1'b0, OSH_PRESS);
         5'd21: u = mk_uop(LD_NONE, MA_XL, MY_T, 1'b0, ADD_PROD, STO_NONE, 1'b0, OSH_PRESS);
         5'd22: u = mk_uop(LD_C00, MA_C01, MY_T, 1'b1, ADD_NONE, STO_X_MULQ, 1'b0, OSH_PRESS);
         5'd23: u = mk_uop(LD_NONE, MA_C01, MY_T, 1'b0, ADD_PROD, STO_NONE, 1'b0, OSH_PRESS);
         5'd24: u = mk_uop(LD_NONE, MA_C30, MY_T, 1'b0, ADD_E, STO_NONE, 1'b0, OSH_PRESS);
         5'd25: u = mk_uop(LD_NONE, MA_C30, MY_T, 1'b0, ADD_X, STO_NONE, 1'b1, OSH_PRESS);
         5'd26: u = mk_uop(LD_C0, MA_C1, MY_T, 1'b1, ADD_NONE, STO_NONE, 1'b0, OSH_TEMP);
         5'd27: u = mk_uop(LD_NONE, MA_C1, MY_T, 1'b0, ADD_PROD, STO_NONE, 1'b1, OSH_TEMP);
         default: u = UOP_NOP;
      endcase
      return u;
   endfunction

endpackage

/* design/ptc_div.sv */
// ----------------------------------------------------------------------------
// ptc_div: restoring unsigned divider
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module ptc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ptc_pkg::QUO_W-1:0]     dividend,
   input  logic [ptc_pkg::SCALE_W-1:0]   divisor,
   output logic                          done,
   output logic [ptc_pkg::QUO_W-1:0]     quotient
);
   import ptc_pkg::*;

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [SCALE_W-1:0] rem_ff, rem_in;
   logic [SCALE_W-1:0] dvs_ff, dvs_in;
   logic [SCALE_W:0]   shifted;
   logic [SCALE_W:0]   diff;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quo_ff[QUO_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         cnt_in = DIV_STEPS;
         quo_in = dividend;
         rem_in = '0;
         // a zero divisor divides as one
         dvs_in = (divisor == '0) ? SCALE_W'(1) : divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[SCALE_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[SCALE_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/ptc_datapath.sv */
// ----------------------------------------------------------------------------
// ptc_datapath: registers, divider, shared multiplier and accumulator
// Executes one microprogram word per cycle and holds the result register.
// ----------------------------------------------------------------------------
module ptc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ptc_pkg::COEF_W-1:0]        csr_wdata,
   input  logic                              req_type,
   input  logic [ptc_pkg::RAW_W-1:0]         req_raw_sample,
   input  ptc_pkg::dp_cmd_type               cmd,
   output ptc_pkg::dp_stat_type              stat,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_result_kind,
   output logic signed [ptc_pkg::OUT_W-1:0]  rsp_comp_value,
   output logic                              rsp_clipped
);
   import ptc_pkg::*;

   logic [COEF_W-1:0]  lo_ff, mi_ff, hg_ff;
   logic [SCALE_W-1:0] tsc_ff, psc_ff;
   logic               kind_ff, neg_ff;
   logic signed [Q_W-1:0]    t_ff, t_in, p_ff, p_in;
   logic signed [INT_W-1:0]  x_ff, x_in, e_ff, e_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic               clip_ff, clip_in;
   out_shift_type      osh_ff, osh_in;
   logic               ov_ff, ov_in;
   logic               ok_ff, ok_in;
   logic signed [OUT_W-1:0] oval_ff, oval_in;
   logic               oclip_ff, oclip_in;

   logic signed [11:0] c0, c1;
   logic signed [19:0] c00, c10;
   logic signed [15:0] c01, c11, c20, c21, c30;

   logic [RAW_W-1:0]   raw_abs;
   logic               div_done;
   logic [QUO_W-1:0]   quo;
   logic signed [Q_W-1:0] qsat;
   logic               qclip;

   logic signed [MA_W-1:0]  ma;
   logic signed [Q_W-1:0]   my;
   logic signed [ACC_W-1:0] ld_val, mq, ov;
   logic signed [INT_W-1:0] st_val;
   logic               st_clip;
   logic               ov_clip;

   assign c0  = lo_ff[47:36];
   assign c1  = lo_ff[35:24];
   assign c00 = lo_ff[23:4];
   assign c10 = {lo_ff[3:0], mi_ff[47:32]};
   assign c01 = mi_ff[31:16];
   assign c11 = mi_ff[15:0];
   assign c20 = hg_ff[47:32];
   assign c21 = hg_ff[31:16];
   assign c30 = hg_ff[15:0];

   assign raw_abs = req_raw_sample[RAW_W-1] ? (~req_raw_sample + RAW_W'(1)) : req_raw_sample;

   ptc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .dividend ({raw_abs, 22'b0}),
      .divisor  (req_type ? psc_ff : tsc_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // truncate toward zero, saturate to the scaled width
   always_comb begin
      qclip = 1'b0;
      if (!neg_ff) begin
         if (quo[QUO_W-1:Q_W-1] != '0) begin
            qclip = 1'b1;
            qsat  = {1'b0, {(Q_W-1){1'b1}}};
         end else begin
            qsat = quo[Q_W-1:0];
         end
      end else begin
         if (quo[QUO_W-1:Q_W-1] != '0 && quo != {{(QUO_W-Q_W){1'b0}}, 1'b1, {(Q_W-1){1'b0}}})
         begin
            qclip = 1'b1;
            qsat  = {1'b1, {(Q_W-1){1'b0}}};
         end else begin
            qsat = -quo[Q_W-1:0];
         end
      end
   end

   always_comb begin
      unique case (cmd.uop.mul_a)
         MA_C30:  ma = MA_W'(c30);
         MA_C21:  ma = MA_W'(c21);
         MA_C01:  ma = MA_W'(c01);
         MA_C1:   ma = MA_W'(c1);
         MA_XH:   ma = MA_W'($signed(x_ff[INT_W-1:24]));
         MA_XL:   ma = {1'b0, x_ff[23:0]};
         default: ma = '0;
      endcase
      my = (cmd.uop.mul_y == MY_T) ? t_ff : p_ff;
   end

   always_comb begin
      unique case (cmd.uop.load)
         LD_ZERO: ld_val = '0;
         LD_C20:  ld_val = ACC_W'(c20) <<< 22;
         LD_C10:  ld_val = ACC_W'(c10) <<< 22;
         LD_C11:  ld_val = ACC_W'(c11) <<< 22;
         LD_C00:  ld_val = ACC_W'(c00) <<< 22;
         LD_C0:   ld_val = ACC_W'(c0) <<< 21;
         default: ld_val = '0;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.uop.load != LD_NONE) begin
         acc_in = ld_val;
      end else begin
         unique case (cmd.uop.add)
            ADD_PROD:    acc_in = acc_ff + ACC_W'(prod_ff);
            ADD_PROD_HI: acc_in = acc_ff + (ACC_W'(prod_ff) <<< 24);
            ADD_X:       acc_in = acc_ff + ACC_W'(x_ff);
            ADD_E:       acc_in = acc_ff + ACC_W'(e_ff);
            default:     acc_in = acc_ff;
         endcase
      end
   end

   // saturate the accumulator (or its Q22 product form) to the 48-bit range
   always_comb begin
      mq = (cmd.uop.store == STO_X_SAT) ? acc_ff : (acc_ff >>> 22);
      st_clip = !((&mq[ACC_W-1:INT_W-1]) || !(|mq[ACC_W-1:INT_W-1]));
      if (st_clip) begin
         st_val = mq[ACC_W-1] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
      end else begin
         st_val = mq[INT_W-1:0];
      end
   end

   always_comb begin
      ov = (osh_ff == OSH_PRESS) ? (acc_ff >>> 18) : (acc_ff >>> 14);
      ov_clip = !((&ov[ACC_W-1:OUT_W-1]) || !(|ov[ACC_W-1:OUT_W-1]));
   end

   always_comb begin
      t_in    = t_ff;
      p_in    = p_ff;
      x_in    = x_ff;
      e_in    = e_ff;
      clip_in = clip_ff;
      osh_in  = osh_ff;
      prod_in = prod_ff;
      if (cmd.start) begin
         clip_in = 1'b0;
      end
      if (div_done) begin
         clip_in = clip_ff | qclip;
         if (kind_ff) begin
            p_in = qsat;
         end else begin
            t_in = qsat;
         end
      end
      if (cmd.uop.mul_en) begin
         prod_in = ma * my;
      end
      unique case (cmd.uop.store)
         STO_X_SAT, STO_X_MULQ: begin
            x_in    = st_val;
            clip_in = clip_ff | st_clip;
         end
         STO_E_MULQ: begin
            e_in    = st_val;
            clip_in = clip_ff | st_clip;
         end
         default: ;
      endcase
      if (cmd.uop.last) begin
         osh_in = cmd.uop.osh;
      end
   end

   always_comb begin
      ov_in    = ov_ff;
      ok_in    = ok_ff;
      oval_in  = oval_ff;
      oclip_in = oclip_ff;
      if (cmd.out_load) begin
         ov_in    = 1'b1;
         ok_in    = kind_ff;
         oclip_in = clip_ff | ov_clip;
         if (ov_clip) begin
            oval_in = ov[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
         end else begin
            oval_in = ov[OUT_W-1:0];
         end
      end else if (rsp_ready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff  <= '0;
         mi_ff  <= '0;
         hg_ff  <= '0;
         tsc_ff <= TEMP_SCALE_RESET;
         psc_ff <= PRESS_SCALE_RESET;
         t_ff   <= '0;
         ov_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            priority case (csr_index)
               CSR_COEF_LOW:    lo_ff  <= csr_wdata;
               CSR_COEF_MID:    mi_ff  <= csr_wdata;
               CSR_COEF_HIGH:   hg_ff  <= csr_wdata;
               CSR_TEMP_SCALE:  tsc_ff <= csr_wdata[SCALE_W-1:0];
               CSR_PRESS_SCALE: psc_ff <= csr_wdata[SCALE_W-1:0];
               default: ;
            endcase
         end
         t_ff  <= t_in;
         ov_ff <= ov_in;
      end
      if (cmd.start) begin
         kind_ff <= req_type;
         neg_ff  <= req_raw_sample[RAW_W-1];
      end
      p_ff     <= p_in;
      x_ff     <= x_in;
      e_ff     <= e_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      clip_ff  <= clip_in;
      osh_ff   <= osh_in;
      ok_ff    <= ok_in;
      oval_ff  <= oval_in;
      oclip_ff <= oclip_in;
   end

   assign stat.div_done  = div_done;
   assign stat.out_free  = !ov_ff || rsp_ready;
   assign rsp_valid       = ov_ff;
   assign rsp_result_kind = ok_ff;
   assign rsp_comp_value  = oval_ff;
   assign rsp_clipped     = oclip_ff;

endmodule

/* design/ptc_ctrl.sv */
// ----------------------------------------------------------------------------
// ptc_ctrl: sequencer
// Accepts a sample, waits for the divider, steps the microprogram and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ptc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  ptc_pkg::dp_stat_type  stat,
   output ptc_pkg::dp_cmd_type   cmd
);
   import ptc_pkg::*;

   ctrl_state_type  state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            kind_ff, kind_in;
   uop_type         uop;

   assign uop = prog(pc_ff);

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      kind_in   = kind_ff;
      req_ready = 1'b0;
      cmd.start    = 1'b0;
      cmd.uop      = UOP_NOP;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               kind_in   = req_type;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               pc_in    = kind_ff ? PRESS_START : TEMP_START;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.uop = uop;
            if (uop.last) begin
               state_in = ST_OUT;
            end else begin
               pc_in = pc_ff + PC_W'(1);
            end
         end
         ST_OUT: begin
            // hold until the output register frees up
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         kind_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

/* design/pressure_temperature_compensation.sv */
// ----------------------------------------------------------------------------
// pressure_temperature_compensation: barometric sensor compensation
// Scales raw temperature and pressure words and applies the calibration
// polynomial, one sample at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one raw 24-bit sample per transaction, req_type selects
//            temperature (0) or pressure (1).
//   rsp_*  : one result per sample, same kind, 40-bit signed value and a
//            clipped flag. A temperature result is in 1/256 degC, a pressure
//            result in 1/16 Pa using the last temperature sample.
//   csr_*  : register writes, index 0..4 (calibration words low, mid, high,
//            temperature scale, pressure scale); other indexes are ignored.
//            Write only while no sample is in flight.
// Sequence: a sample occupies the block from acceptance until its result is
//   in the output register: first the one-bit-per-cycle scaling divider and
//   its done flag, then the microprogram on the shared 25x26 multiplier and
//   accumulator, then the load of the output register. The next sample is
//   taken once the previous result is in the output register.
// Reset: calibration cleared, scales at their defaults, stored temperature
//   zero. A stalled receiver holds the result in the output register; the
//   next sample computes and then waits for that register to free up.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ptc_pkg::COEF_W-1:0]        csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [ptc_pkg::RAW_W-1:0]         req_raw_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_result_kind,
   output logic signed [ptc_pkg::OUT_W-1:0]  rsp_comp_value,
   output logic                              rsp_clipped
);
   import ptc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   ptc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptc_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_type        (req_type),
      .req_raw_sample  (req_raw_sample),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_comp_value  (rsp_comp_value),
      .rsp_clipped     (rsp_clipped)
   );

endmodule
